FILE: sv/pcde_pkg.sv
`timescale 1ns / 1ps
package pcde_pkg;

	// Polynomial shape and store size
	localparam int DEGREE       = 3;
	localparam int MAX_SEGMENTS = 16;
	localparam int NCOEF        = DEGREE + 1;
	localparam int NLANES       = 4;

	// Field widths
	localparam int TAU_W  = 17;
	localparam int FRAC_W = 16;
	localparam int COEF_W = 32;
	localparam int ACC_W  = 48;
	localparam int SEG_W  = 5;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 6;

	localparam int STEP_W = (NCOEF > 1) ? $clog2(NCOEF) : 1;
	localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int FACT_W = 13;
	localparam int PROD_W = ACC_W + TAU_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int SPAN_W = TAU_W + CNT_W;

	// Slot index split: multiply by reciprocal of NCOEF
	localparam int IDX_SHIFT = 16;
	localparam int RECIP_W   = IDX_SHIFT + 1;
	localparam int IDX_RECIP = ((1 << IDX_SHIFT) + NCOEF - 1) / NCOEF;

	localparam logic [TAU_W-1:0] TAU_ONE = TAU_W'(1 << FRAC_W);
	localparam logic [SPAN_W:0]  CEIL_ADD = (SPAN_W + 1)'((1 << FRAC_W) - 1);

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(ACC_W - 1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [SEG_W-1:0]              seg;
		logic [TAU_W-1:0]              tau;
		logic [NCOEF-1:0][COEF_W-1:0]  coef;
		logic [NLANES-1:0][ACC_W-1:0]  acc;
	} eval_t;

	typedef struct packed {
		logic [SEG_W-1:0]              seg;
		logic [TAU_W-1:0]              tau;
		logic [NCOEF-1:0][COEF_W-1:0]  coef;
		logic [NLANES-1:0][ACC_W-1:0]  acc;
		logic [NLANES-1:0][PROD_W-1:0] prod;
	} prod_t;

	// n * (n-1) * ... * (n-d+1)
	function automatic logic [FACT_W-1:0] fall(input int n, input int d);
		logic [FACT_W-1:0] f;
		f = FACT_W'(1);
		for (int j = 0; j < NLANES; j++) begin
			if (j < d) f = FACT_W'(f * FACT_W'(n - j));
		end
		return f;
	endfunction

	function automatic logic [ACC_W-1:0] scale(input logic [COEF_W-1:0] c,
		input logic [FACT_W-1:0] f);
		logic signed [COEF_W+FACT_W:0] p;
		p = $signed(c) * $signed({1'b0, f});
		return ACC_W'(p);
	endfunction

	function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic [ACC_W-1:0] r;
		if (x > SAT_HI) r = SAT_HI[ACC_W-1:0];
		else if (x < SAT_LO) r = SAT_LO[ACC_W-1:0];
		else r = x[ACC_W-1:0];
		return r;
	endfunction

endpackage

FILE: sv/piecewise_cubic_eval_with_derivs_core.sv
`timescale 1ns / 1ps
// Piecewise cubic evaluator with value and first three derivatives.
// Input channel (in_valid / in_stall): a word with mode 0 stores coef_value
// in slot coef_index of the coefficient store; mode 1 evaluates at tau and
// gives one result word. Store words give no result.
// Output channel (out_valid / out_stall): segment, value and derivatives,
// signed Q32.16, saturated to 48 bits.
// Config channel (cfg_valid / cfg_ready / cfg_data): segment count; write
// only while no evaluation is in flight. cfg_ready is always high.
// Pipeline: an evaluate word passes two stages of store read and set-up,
// then a multiply stage and a round/add stage for each of the three Horner
// steps, before out_valid rises.
// Throughput: one word per cycle while in_stall is low; each stage holds one word and empty
// stages close up, so in_stall rises only when every stage is full.
// When the receiver stalls, the output word holds and the pipeline fills.
// Reset clears all valid flags and sets the segment count to one; the
// coefficient store is not cleared and must be written before it is read.
module piecewise_cubic_eval_with_derivs_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pcde_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [pcde_pkg::IDX_W-1:0]         coef_index,
	input  logic signed [pcde_pkg::COEF_W-1:0] coef_value,
	input  logic [pcde_pkg::TAU_W-1:0]         tau,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pcde_pkg::SEG_W-1:0]         segment,
	output logic signed [pcde_pkg::ACC_W-1:0]  value,
	output logic signed [pcde_pkg::ACC_W-1:0]  first_derivative,
	output logic signed [pcde_pkg::ACC_W-1:0]  second_derivative,
	output logic signed [pcde_pkg::ACC_W-1:0]  third_derivative
);
	logic [pcde_pkg::CNT_W-1:0] segment_count_q;
	logic                       front_ready;
	pcde_pkg::eval_t            chain_data [pcde_pkg::DEGREE+1];
	logic [pcde_pkg::DEGREE:0]  chain_valid;
	logic [pcde_pkg::DEGREE:0]  chain_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= pcde_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			segment_count_q <= cfg_data;
		end
	end

	pcde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_count  (segment_count_q),
		.in_valid   (in_valid),
		.in_ready   (front_ready),
		.mode       (mode),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.tau        (tau),
		.dn_valid   (chain_valid[0]),
		.dn_ready   (chain_ready[0]),
		.dn_data    (chain_data[0])
	);

	assign in_stall = !front_ready;

	for (genvar k = 1; k <= pcde_pkg::DEGREE; k++) begin : g_step
		pcde_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (pcde_pkg::STEP_W'(k)),
			.up_valid (chain_valid[k-1]),
			.up_ready (chain_ready[k-1]),
			.up_data  (chain_data[k-1]),
			.dn_valid (chain_valid[k]),
			.dn_ready (chain_ready[k]),
			.dn_data  (chain_data[k])
		);
	end

	assign chain_ready[pcde_pkg::DEGREE] = !out_stall;
	assign out_valid         = chain_valid[pcde_pkg::DEGREE];
	assign segment           = chain_data[pcde_pkg::DEGREE].seg;
	assign value             = chain_data[pcde_pkg::DEGREE].acc[0];
	assign first_derivative  = chain_data[pcde_pkg::DEGREE].acc[1];
	assign second_derivative = chain_data[pcde_pkg::DEGREE].acc[2];
	assign third_derivative  = chain_data[pcde_pkg::DEGREE].acc[3];
endmodule

FILE: sv/pcde_ram.sv
`timescale 1ns / 1ps
module pcde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

FILE: sv/pcde_front.sv
`timescale 1ns / 1ps
module pcde_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pcde_pkg::CNT_W-1:0]         seg_count,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [pcde_pkg::IDX_W-1:0]         coef_index,
	input  logic [pcde_pkg::COEF_W-1:0]        coef_value,
	input  logic [pcde_pkg::TAU_W-1:0]         tau,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output pcde_pkg::eval_t                    dn_data
);
	logic                              accept;
	logic [pcde_pkg::TAU_W-1:0]        tau_sat;
	logic [pcde_pkg::CNT_W-1:0]        segs_eff;
	logic [pcde_pkg::SPAN_W-1:0]       span;
	logic [pcde_pkg::SPAN_W:0]         span_up;
	logic [pcde_pkg::SPAN_W-pcde_pkg::FRAC_W:0] seg_raw;
	logic [pcde_pkg::SEG_W-1:0]        seg_sel;
	logic [pcde_pkg::SEG_AW-1:0]       rd_addr;

	logic [pcde_pkg::IDX_W+pcde_pkg::RECIP_W-1:0] idx_prod;
	logic [pcde_pkg::IDX_W-1:0]        slot_q;
	logic [pcde_pkg::IDX_W-1:0]        slot_r;
	logic                              slot_ok;

	logic [pcde_pkg::COEF_W-1:0]       bank_rd [pcde_pkg::NCOEF];

	logic                              valid_s1;
	logic [pcde_pkg::SEG_W-1:0]        seg_s1;
	logic [pcde_pkg::TAU_W-1:0]        tau_s1;
	logic                              valid_s2;
	pcde_pkg::eval_t                   data_s2;
	pcde_pkg::eval_t                   init_next;
	logic                              ready_s1;
	logic                              ready_s2;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign accept   = in_valid && ready_s1;

	// Segment select: max(1, ceil(tau * segs)), capped at segs
	always_comb begin
		tau_sat = (tau > pcde_pkg::TAU_ONE) ? pcde_pkg::TAU_ONE : tau;
		if (seg_count == '0) segs_eff = pcde_pkg::CNT_W'(1);
		else if (seg_count > pcde_pkg::CNT_W'(pcde_pkg::MAX_SEGMENTS))
			segs_eff = pcde_pkg::CNT_W'(pcde_pkg::MAX_SEGMENTS);
		else segs_eff = seg_count;
		span    = pcde_pkg::SPAN_W'(tau_sat * segs_eff);
		span_up = {1'b0, span} + pcde_pkg::CEIL_ADD;
		seg_raw = span_up[pcde_pkg::SPAN_W:pcde_pkg::FRAC_W];
		if (seg_raw == '0) seg_sel = pcde_pkg::SEG_W'(1);
		else if (seg_raw > ($bits(seg_raw))'(segs_eff)) seg_sel = segs_eff;
		else seg_sel = pcde_pkg::SEG_W'(seg_raw);
		rd_addr = pcde_pkg::SEG_AW'(seg_sel - pcde_pkg::SEG_W'(1));
	end

	// Split slot index into segment and power position
	always_comb begin
		idx_prod = ($bits(idx_prod))'(coef_index) *
			($bits(idx_prod))'(pcde_pkg::IDX_RECIP);
		slot_q   = pcde_pkg::IDX_W'(idx_prod >> pcde_pkg::IDX_SHIFT);
		slot_r   = coef_index - pcde_pkg::IDX_W'(slot_q * pcde_pkg::IDX_W'(pcde_pkg::NCOEF));
		slot_ok  = slot_q < pcde_pkg::IDX_W'(pcde_pkg::MAX_SEGMENTS);
	end

	for (genvar b = 0; b < pcde_pkg::NCOEF; b++) begin : g_bank
		logic bank_we;
		assign bank_we = accept && !mode && slot_ok &&
			(slot_r == pcde_pkg::IDX_W'(b));
		pcde_ram #(
			.WIDTH(pcde_pkg::COEF_W),
			.DEPTH(pcde_pkg::MAX_SEGMENTS)
		) u_bank (
			.clk   (clk),
			.we    (bank_we),
			.waddr (pcde_pkg::SEG_AW'(slot_q)),
			.wdata (coef_value),
			.re    (ready_s1),
			.raddr (rd_addr),
			.rdata (bank_rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid && mode;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1 <= seg_sel;
			tau_s1 <= tau_sat;
		end
	end

	// Leading coefficient, scaled for each derivative
	always_comb begin
		init_next.seg = seg_s1;
		init_next.tau = tau_s1;
		for (int b = 0; b < pcde_pkg::NCOEF; b++) init_next.coef[b] = bank_rd[b];
		for (int d = 0; d < pcde_pkg::NLANES; d++) begin
			if (d <= pcde_pkg::DEGREE)
				init_next.acc[d] = pcde_pkg::scale(bank_rd[0],
					pcde_pkg::fall(pcde_pkg::DEGREE, d));
			else
				init_next.acc[d] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) data_s2 <= init_next;
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;
endmodule

FILE: sv/pcde_step.sv
`timescale 1ns / 1ps
module pcde_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcde_pkg::STEP_W-1:0] step,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  pcde_pkg::eval_t             up_data,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output pcde_pkg::eval_t             dn_data
);
	logic            valid_s1;
	logic            valid_s2;
	logic            ready_s1;
	logic            ready_s2;
	pcde_pkg::prod_t prod_next;
	pcde_pkg::prod_t prod_s1;
	pcde_pkg::eval_t add_next;
	pcde_pkg::eval_t data_s2;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// Multiply each accumulator by tau
	always_comb begin
		prod_next.seg  = up_data.seg;
		prod_next.tau  = up_data.tau;
		prod_next.coef = up_data.coef;
		prod_next.acc  = up_data.acc;
		for (int d = 0; d < pcde_pkg::NLANES; d++)
			prod_next.prod[d] = pcde_pkg::PROD_W'($signed(up_data.acc[d]) *
				$signed({1'b0, up_data.tau}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) prod_s1 <= prod_next;
	end

	// Round half up, saturate, add next scaled coefficient, saturate again
	always_comb begin
		logic signed [pcde_pkg::SUM_W-1:0] rnd;
		logic [pcde_pkg::ACC_W-1:0]        rnd_sat;
		logic [pcde_pkg::ACC_W-1:0]        addend;
		logic signed [pcde_pkg::SUM_W-1:0] sum;
		add_next.seg  = prod_s1.seg;
		add_next.tau  = prod_s1.tau;
		add_next.coef = prod_s1.coef;
		for (int d = 0; d < pcde_pkg::NLANES; d++) begin
			rnd = $signed({prod_s1.prod[d][pcde_pkg::PROD_W-1], prod_s1.prod[d]}) +
				pcde_pkg::ROUND_HALF;
			rnd = rnd >>> pcde_pkg::FRAC_W;
			rnd_sat = pcde_pkg::sat_acc(rnd);
			addend = pcde_pkg::scale(prod_s1.coef[step],
				pcde_pkg::fall(pcde_pkg::DEGREE - int'(step), d));
			sum = pcde_pkg::SUM_W'($signed(rnd_sat)) + pcde_pkg::SUM_W'($signed(addend));
			// Lanes whose polynomial is already done hold their value
			if (d <= pcde_pkg::DEGREE - int'(step))
				add_next.acc[d] = pcde_pkg::sat_acc(sum);
			else
				add_next.acc[d] = prod_s1.acc[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) data_s2 <= add_next;
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;
endmodule

FILE: tb/sv/pcde_tb_pkg.sv
`timescale 1ns / 1ps
package pcde_tb_pkg;

	// Kind of input word
	typedef enum logic {
		MODE_STORE = 1'b0,
		MODE_EVAL  = 1'b1
	} word_mode_e;

endpackage

FILE: tb/sv/pcde_checker.sv
`timescale 1ns / 1ps
module pcde_checker
	import pcde_pkg::*;
	import pcde_tb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CNT_W-1:0]          cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      mode,
	input  logic [IDX_W-1:0]          coef_index,
	input  logic signed [COEF_W-1:0]  coef_value,
	input  logic [TAU_W-1:0]          tau,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [SEG_W-1:0]          segment,
	input  logic signed [ACC_W-1:0]   value,
	input  logic signed [ACC_W-1:0]   first_derivative,
	input  logic signed [ACC_W-1:0]   second_derivative,
	input  logic signed [ACC_W-1:0]   third_derivative,
	output int                        errors,
	output int                        outstanding
);

	typedef struct packed {
		logic [SEG_W-1:0]             segment;
		logic [NLANES-1:0][ACC_W-1:0] deriv;
	} warp_result_t;

	localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -(64'sd1 <<< (ACC_W - 1));

	logic signed [COEF_W-1:0] coef_mem [MAX_SEGMENTS*NCOEF];
	logic [CNT_W-1:0]         seg_cnt = CNT_W'(1);
	warp_result_t             pending_evals [$];
	warp_result_t             want, got;
	int                       fail_cnt = 0;
	string                    lane_name [NLANES] = '{"value", "first_derivative",
		"second_derivative", "third_derivative"};

	function automatic longint clip_acc(longint x);
		if (x > ACC_MAX) return ACC_MAX;
		if (x < ACC_MIN) return ACC_MIN;
		return x;
	endfunction

	// Horner in global tau on the derivative-scaled coefficients, highest power first
	function automatic warp_result_t predict_warp(logic [TAU_W-1:0] t_in);
		warp_result_t r;
		longint t, segs, seg, acc, mult, c;
		int base;
		t = (t_in > TAU_ONE) ? TAU_ONE : t_in;
		segs = (seg_cnt == 0) ? 1 : ((seg_cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_cnt);
		seg = (t * segs + ((64'sd1 <<< FRAC_W) - 1)) >>> FRAC_W;
		if (seg < 1) seg = 1;
		if (seg > segs) seg = segs;
		base = NCOEF * int'(seg - 1);
		r.segment = SEG_W'(seg);
		for (int d = 0; d < NLANES; d++) begin
			acc = 0;
			for (int k = 0; k <= DEGREE - d; k++) begin
				mult = 1;
				for (int j = 0; j < d; j++) mult = mult * (DEGREE - k - j);
				if (k > 0) acc = clip_acc((acc * t + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W);
				c = coef_mem[base + k];
				acc = clip_acc(acc + c * mult);
			end
			r.deriv[d] = ACC_W'(acc);
		end
		return r;
	endfunction

	task automatic check_field(string name, logic signed [ACC_W-1:0] exp_v,
		logic signed [ACC_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt = CNT_W'(1);
			pending_evals.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.segment = segment;
				got.deriv = {third_derivative, second_derivative, first_derivative, value};
				if (pending_evals.size() == 0) begin
					$error("result word with no evaluation pending");
					fail_cnt++;
				end else begin
					want = pending_evals.pop_front();
					check_field("segment", want.segment, got.segment);
					for (int d = 0; d < NLANES; d++)
						check_field(lane_name[d], want.deriv[d], got.deriv[d]);
				end
			end
			// an input word accepted on this edge still sees the old segment count
			if (in_valid && !in_stall) begin
				if (mode == MODE_STORE)
					coef_mem[coef_index] = coef_value;
				else
					pending_evals.insert(pending_evals.size(), predict_warp(tau));
			end
			if (cfg_valid && cfg_ready)
				seg_cnt = cfg_data;
			errors <= fail_cnt;
			outstanding <= pending_evals.size();
		end
	end

endmodule

FILE: tb/sv/piecewise_cubic_eval_with_derivs_core_tb.sv
`timescale 1ns / 1ps
module piecewise_cubic_eval_with_derivs_core_tb;
	import pcde_pkg::*;
	import pcde_tb_pkg::*;

	localparam int SETTLE      = 12;
	localparam int LIMIT       = 600000;
	localparam int PHASE_WORDS = 130;
	localparam int NPHASES     = 12;
	localparam int NSLOTS      = MAX_SEGMENTS * NCOEF;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CNT_W-1:0]         cfg_data = CNT_W'(1);
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     mode = MODE_STORE;
	logic [IDX_W-1:0]         coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic [TAU_W-1:0]         tau = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [SEG_W-1:0]         segment;
	logic signed [ACC_W-1:0]  value, first_derivative, second_derivative, third_derivative;

	int errors, outstanding;
	int cycles = 0;
	bit idle_on = 1'b1;
	int eff_segs = 1;

	piecewise_cubic_eval_with_derivs_core i_dut (.*);

	pcde_checker i_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Mostly short, now and then long
	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return $signed(COEF_W'($urandom_range(0, 1 << 20))) - (1 <<< 19);
		if (r < 80) return $urandom;
		case ($urandom_range(0, 4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			default: return 32'sh0000_0001;
		endcase
	endfunction

	function automatic logic [TAU_W-1:0] pick_tau();
		int r, k, b;
		r = $urandom_range(0, 99);
		if (r < 60) return TAU_W'($urandom_range(0, 1 << FRAC_W));
		if (r < 80) begin
			// land on or beside a segment boundary
			k = $urandom_range(1, eff_segs);
			b = (k << FRAC_W) / eff_segs;
			return TAU_W'(b - 1 + $urandom_range(0, 2));
		end
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return TAU_W'(1);
				2: return TAU_W'((1 << FRAC_W) - 1);
				default: return TAU_ONE;
			endcase
		end
		return TAU_W'($urandom_range((1 << FRAC_W) + 1, (1 << TAU_W) - 1));
	endfunction

	task automatic send_word(word_mode_e m, logic [IDX_W-1:0] idx,
		logic signed [COEF_W-1:0] val, logic [TAU_W-1:0] t);
		int gap;
		gap = idle_on ? rand_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		coef_index <= idx;
		coef_value <= val;
		tau <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic store_coef(logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
		send_word(MODE_STORE, idx, val, TAU_W'($urandom_range(0, (1 << TAU_W) - 1)));
	endtask

	task automatic eval_at(logic [TAU_W-1:0] t);
		send_word(MODE_EVAL, IDX_W'($urandom_range(0, NSLOTS - 1)), $urandom, t);
	endtask

	// Hold the sender until every evaluation is back, then let stores settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_segments(logic [CNT_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		eff_segs = (n == 0) ? 1 : ((n > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(n));
	endtask

	initial begin
		int n, r;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else begin
				n = rand_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [CNT_W-1:0] phase_segs [NPHASES];
		phase_segs = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd17, 5'd1,
			5'd13, 5'd0};
		phase_segs[NPHASES-1] = CNT_W'($urandom_range(0, 31));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one segment after reset: extreme coefficients first, then ordinary ones
		store_coef(0, 32'sh7FFF_FFFF);
		store_coef(1, 32'sh8000_0000);
		store_coef(2, 32'sh7FFF_FFFF);
		store_coef(3, 32'sh8000_0000);
		eval_at('0);
		eval_at(TAU_ONE);
		eval_at(TAU_W'((1 << TAU_W) - 1));
		eval_at(TAU_W'(1 << (FRAC_W - 1)));
		store_coef(0, 32'sh0001_0000);
		store_coef(1, -32'sh0002_0000);
		store_coef(2, 32'sh0000_8000);
		store_coef(3, 32'sh0000_4000);
		store_coef(IDX_W'(NSLOTS - 1), 32'shFFFF_FFFF);
		eval_at('0);
		eval_at(TAU_W'(1));
		eval_at(TAU_W'((1 << FRAC_W) - 1));
		eval_at(TAU_ONE);
		eval_at(TAU_W'((1 << FRAC_W) + 1));
		drain();

		for (int p = 0; p < NPHASES; p++) begin
			set_segments(phase_segs[p]);
			idle_on = (p % 4 != 3);
			if (p == 0) begin
				for (int s = 0; s < NSLOTS; s++) store_coef(IDX_W'(s), pick_coef());
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(0, 99) < 70) eval_at(pick_tau());
				else store_coef(IDX_W'($urandom_range(0, NSLOTS - 1)), pick_coef());
				if (p == 5 && i == PHASE_WORDS / 2) drain();
			end
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: piecewise_cubic_eval_with_derivs_core.f
sv/pcde_pkg.sv
sv/pcde_ram.sv
sv/pcde_front.sv
sv/pcde_step.sv
sv/piecewise_cubic_eval_with_derivs_core.sv
tb/sv/pcde_tb_pkg.sv
tb/sv/pcde_checker.sv
tb/sv/piecewise_cubic_eval_with_derivs_core_tb.sv
